### design/pls_pkg.sv
// shared types, constants and configuration codes of the line follow steering unit
`timescale 1ns / 1ps

package pls_pkg;

    // line sensor full scale; the error percent is taken against half of it
    localparam int LINE_FULL_SCALE = 6000;
    localparam int PCT_DIVISOR_RAW = LINE_FULL_SCALE / 2 / 100;
    localparam int PCT_DIVISOR     = (PCT_DIVISOR_RAW < 1) ? 1 : PCT_DIVISOR_RAW;

    // |err| below these bounds means percent at most 20, 40 and 70
    localparam logic [16:0] NEAR_BOUND = 17'(21 * PCT_DIVISOR);
    localparam logic [16:0] MID_BOUND  = 17'(41 * PCT_DIVISOR);
    localparam logic [16:0] WIDE_BOUND = 17'(71 * PCT_DIVISOR);

    localparam int          PWM_FULL   = 65535;
    localparam logic [9:0]  SPEED_UNIT = 10'(PWM_FULL / 100);

    // reciprocal of 100 for 16 bit gains: q = (g * GAIN_RECIP) >> GAIN_SHIFT
    localparam int          GAIN_SHIFT = 23;
    localparam logic [16:0] GAIN_RECIP = 17'(((64'd1 << GAIN_SHIFT) + 64'd99) / 64'd100);

    // reciprocal of 100 for 30 bit remainder products
    localparam int          LO_SHIFT     = 37;
    localparam longint unsigned LO_RECIP_FULL = ((64'd1 << LO_SHIFT) + 64'd99) / 64'd100;
    localparam logic [30:0] LO_RECIP     = 31'(LO_RECIP_FULL);

    // reciprocal of 5 for the 80 and 60 percent base speeds
    localparam int          FIFTH_SHIFT = 21;
    localparam logic [18:0] FIFTH_RECIP = 19'(((64'd1 << FIFTH_SHIFT) + 64'd4) / 64'd5);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDUP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED  = 3'd4;

    localparam int PID_W = 35;

    typedef enum logic [1:0] {
        ZONE_NEAR,
        ZONE_MID,
        ZONE_WIDE,
        ZONE_FAR
    } zone_t;

    // gains held as quotient and remainder of a division by 100
    typedef struct packed {
        logic [9:0]  p_quo;
        logic [6:0]  p_rem;
        logic [9:0]  i_quo;
        logic [6:0]  i_rem;
        logic [9:0]  d_quo;
        logic [6:0]  d_rem;
        logic [22:0] windup;
        logic [16:0] base_full;
        logic [16:0] base_80;
        logic [16:0] base_60;
    } cfg_t;

    typedef struct packed {
        logic signed [PID_W-1:0] pid;
        zone_t                   zone;
    } pid_word_t;

endpackage

### design/pls_cfg.sv
// configuration registers with gains split by 100 and derived base speeds
`timescale 1ns / 1ps

module pls_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output pls_pkg::cfg_t                    cfg
);
    import pls_pkg::*;

    logic [9:0]  p_quo_reg, i_quo_reg, d_quo_reg;
    logic [6:0]  p_rem_reg, i_rem_reg, d_rem_reg;
    logic [22:0] windup_reg;
    logic [16:0] full_reg, base80_reg, base60_reg;

    logic [15:0] gain_in;
    logic [32:0] gain_prod;
    logic [9:0]  gain_quo;
    logic [15:0] gain_hundreds;
    logic [15:0] gain_diff;
    logic [6:0]  gain_rem;
    logic [16:0] full_next;
    logic [18:0] full_x4, full_x3;
    logic [37:0] prod_80, prod_60;
    logic [16:0] base80_next, base60_next;

    always_comb begin
        gain_in       = cfg_wdata[15:0];
        gain_prod     = 33'(gain_in) * 33'(GAIN_RECIP);
        gain_quo      = gain_prod[GAIN_SHIFT+9:GAIN_SHIFT];
        // 100 * q as shifts: 64 + 32 + 4
        gain_hundreds = (16'(gain_quo) << 6) + (16'(gain_quo) << 5) + (16'(gain_quo) << 2);
        gain_diff     = gain_in - gain_hundreds;
        gain_rem      = gain_diff[6:0];

        full_next     = 17'(cfg_wdata[6:0]) * 17'(SPEED_UNIT);

        // full * 8 / 10 = full * 4 / 5, full * 6 / 10 = full * 3 / 5
        full_x4       = {full_reg, 2'b00};
        full_x3       = {1'b0, full_reg, 1'b0} + 19'(full_reg);
        prod_80       = 38'(full_x4) * 38'(FIFTH_RECIP);
        prod_60       = 38'(full_x3) * 38'(FIFTH_RECIP);
        base80_next   = prod_80[FIFTH_SHIFT+16:FIFTH_SHIFT];
        base60_next   = prod_60[FIFTH_SHIFT+16:FIFTH_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_quo_reg  <= '0;
            p_rem_reg  <= '0;
            i_quo_reg  <= '0;
            i_rem_reg  <= '0;
            d_quo_reg  <= '0;
            d_rem_reg  <= '0;
            windup_reg <= '0;
            full_reg   <= '0;
            base80_reg <= '0;
            base60_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_PROP_GAIN: begin
                        p_quo_reg <= gain_quo;
                        p_rem_reg <= gain_rem;
                    end
                    REG_INTEG_GAIN: begin
                        i_quo_reg <= gain_quo;
                        i_rem_reg <= gain_rem;
                    end
                    REG_DERIV_GAIN: begin
                        d_quo_reg <= gain_quo;
                        d_rem_reg <= gain_rem;
                    end
                    REG_WINDUP: begin
                        windup_reg <= cfg_wdata[22:0];
                    end
                    REG_MAX_SPEED: begin
                        full_reg <= full_next;
                    end
                    default: begin
                    end
                endcase
            end
            base80_reg <= base80_next;
            base60_reg <= base60_next;
        end
    end

    always_comb begin
        cfg.p_quo     = p_quo_reg;
        cfg.p_rem     = p_rem_reg;
        cfg.i_quo     = i_quo_reg;
        cfg.i_rem     = i_rem_reg;
        cfg.d_quo     = d_quo_reg;
        cfg.d_rem     = d_rem_reg;
        cfg.windup    = windup_reg;
        cfg.base_full = full_reg;
        cfg.base_80   = base80_reg;
        cfg.base_60   = base60_reg;
    end

endmodule

### design/pls_pid.sv
// pid pipeline: error and integral state, split multiplies, divide by 100, term sum
`timescale 1ns / 1ps

module pls_pid (
    input  logic                aclk,
    input  logic                aresetn,
    input  pls_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         measured_position,
    input  logic [15:0]         target_position,
    output logic                out_valid,
    input  logic                out_ready,
    output pls_pkg::pid_word_t  out_word
);
    import pls_pkg::*;

    localparam int STAGES = 4;

    // floor(v / 100) for v below 2**30
    function automatic logic [23:0] div100_lo(input logic [29:0] v);
        logic [60:0] prod;
        prod = 61'(v) * 61'(LO_RECIP);
        return prod[LO_SHIFT+23:LO_SHIFT];
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;

    logic signed [23:0] integ_reg;
    logic signed [16:0] prev_reg;

    // stage 1
    logic               e_neg1_reg, i_neg1_reg, d_neg1_reg;
    logic [15:0]        e_mag1_reg;
    logic [22:0]        i_mag1_reg;
    logic [16:0]        d_mag1_reg;
    zone_t              zone1_reg;
    // stage 2
    logic               e_neg2_reg, i_neg2_reg, d_neg2_reg;
    logic [25:0]        p_hi2_reg;
    logic [22:0]        p_lo2_reg;
    logic [32:0]        i_hi2_reg;
    logic [29:0]        i_lo2_reg;
    logic [26:0]        d_hi2_reg;
    logic [23:0]        d_lo2_reg;
    zone_t              zone2_reg;
    // stage 3
    logic               e_neg3_reg, i_neg3_reg, d_neg3_reg;
    logic [25:0]        p_hi3_reg;
    logic [32:0]        i_hi3_reg;
    logic [26:0]        d_hi3_reg;
    logic [23:0]        p_q3_reg, i_q3_reg, d_q3_reg;
    zone_t              zone3_reg;
    // stage 4
    logic signed [PID_W-1:0] pid4_reg;
    zone_t                   zone4_reg;

    logic signed [16:0] err;
    logic signed [24:0] isum, lim_pos, lim_neg;
    logic signed [23:0] integ_next;
    logic signed [17:0] diff;
    logic [16:0]        e_abs;
    logic [23:0]        i_abs;
    logic [17:0]        d_abs;
    zone_t              zone_next;
    logic [33:0]        p_mag, i_mag, d_mag;
    logic signed [PID_W-1:0] p_term, i_term, d_term, pid_next;

    always_comb begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    // stage 1 logic
    always_comb begin
        err     = $signed({1'b0, target_position}) - $signed({1'b0, measured_position});
        isum    = $signed({integ_reg[23], integ_reg}) + $signed({{8{err[16]}}, err});
        lim_pos = $signed({2'b00, cfg.windup});
        lim_neg = -lim_pos;
        if (isum > lim_pos) begin
            integ_next = lim_pos[23:0];
        end else if (isum < lim_neg) begin
            integ_next = lim_neg[23:0];
        end else begin
            integ_next = isum[23:0];
        end
        diff  = $signed({err[16], err}) - $signed({prev_reg[16], prev_reg});
        e_abs = err[16] ? (17'd0 - err) : err;
        i_abs = integ_next[23] ? (24'd0 - integ_next) : integ_next;
        d_abs = diff[17] ? (18'd0 - diff) : diff;
        if ({1'b0, e_abs[15:0]} < NEAR_BOUND) begin
            zone_next = ZONE_NEAR;
        end else if ({1'b0, e_abs[15:0]} < MID_BOUND) begin
            zone_next = ZONE_MID;
        end else if ({1'b0, e_abs[15:0]} < WIDE_BOUND) begin
            zone_next = ZONE_WIDE;
        end else begin
            zone_next = ZONE_FAR;
        end
    end

    // stage 4 logic: |x| * g / 100 = |x| * quo + floor(|x| * rem / 100)
    always_comb begin
        p_mag    = 34'(p_hi3_reg) + 34'(p_q3_reg);
        i_mag    = 34'(i_hi3_reg) + 34'(i_q3_reg);
        d_mag    = 34'(d_hi3_reg) + 34'(d_q3_reg);
        p_term   = e_neg3_reg ? $signed(35'd0 - 35'(p_mag)) : $signed(35'(p_mag));
        i_term   = i_neg3_reg ? $signed(35'd0 - 35'(i_mag)) : $signed(35'(i_mag));
        d_term   = d_neg3_reg ? $signed(35'd0 - 35'(d_mag)) : $signed(35'(d_mag));
        pid_next = p_term + i_term + d_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            integ_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (in_valid && rdy[0]) begin
                integ_reg <= integ_next;
                prev_reg  <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            e_neg1_reg <= err[16];
            i_neg1_reg <= integ_next[23];
            d_neg1_reg <= diff[17];
            e_mag1_reg <= e_abs[15:0];
            i_mag1_reg <= i_abs[22:0];
            d_mag1_reg <= d_abs[16:0];
            zone1_reg  <= zone_next;
        end
        if (rdy[1]) begin
            e_neg2_reg <= e_neg1_reg;
            i_neg2_reg <= i_neg1_reg;
            d_neg2_reg <= d_neg1_reg;
            p_hi2_reg  <= 26'(e_mag1_reg) * 26'(cfg.p_quo);
            p_lo2_reg  <= 23'(e_mag1_reg) * 23'(cfg.p_rem);
            i_hi2_reg  <= 33'(i_mag1_reg) * 33'(cfg.i_quo);
            i_lo2_reg  <= 30'(i_mag1_reg) * 30'(cfg.i_rem);
            d_hi2_reg  <= 27'(d_mag1_reg) * 27'(cfg.d_quo);
            d_lo2_reg  <= 24'(d_mag1_reg) * 24'(cfg.d_rem);
            zone2_reg  <= zone1_reg;
        end
        if (rdy[2]) begin
            e_neg3_reg <= e_neg2_reg;
            i_neg3_reg <= i_neg2_reg;
            d_neg3_reg <= d_neg2_reg;
            p_hi3_reg  <= p_hi2_reg;
            i_hi3_reg  <= i_hi2_reg;
            d_hi3_reg  <= d_hi2_reg;
            p_q3_reg   <= div100_lo(30'(p_lo2_reg));
            i_q3_reg   <= div100_lo(i_lo2_reg);
            d_q3_reg   <= div100_lo(30'(d_lo2_reg));
            zone3_reg  <= zone2_reg;
        end
        if (rdy[3]) begin
            pid4_reg  <= pid_next;
            zone4_reg <= zone3_reg;
        end
    end

    assign out_valid     = vld_reg[STAGES-1];
    assign out_word.pid  = pid4_reg;
    assign out_word.zone = zone4_reg;

endmodule

### design/pls_mix.sv
// zone mixing of the pid value into motor speeds and the pwm output register
`timescale 1ns / 1ps

module pls_mix (
    input  logic                aclk,
    input  logic                aresetn,
    input  pls_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pls_pkg::pid_word_t  in_word,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata
);
    import pls_pkg::*;

    // clamp to +-b, then split into reverse flag and magnitude
    function automatic logic [18:0] far_fold(input logic signed [35:0] s,
                                             input logic signed [35:0] b);
        logic [35:0] mag;
        if (s[35]) begin
            mag = (s < -b) ? 36'(b) : (36'd0 - s);
        end else begin
            mag = (s > b) ? 36'(b) : 36'(s);
        end
        // a zero base clamps the speed to zero, which is never reversed
        return {s[35] & (|b), mag[17:0]};
    endfunction

    logic        vld5_reg, vld6_reg;
    logic        rdy5, rdy6;

    logic [17:0] left_mag5_reg, right_mag5_reg;
    logic        left_rev5_reg, right_rev5_reg;

    logic [15:0] left_pwm_reg, right_pwm_reg;
    logic        left_rev_reg, right_rev_reg;

    logic signed [35:0] base_s, pid_s, pid_lim, sl, sr;
    logic [18:0]        left_fold, right_fold;
    logic [17:0]        left_mag_next, right_mag_next;
    logic               left_rev_next, right_rev_next;

    assign rdy6     = !vld6_reg || m_tready;
    assign rdy5     = !vld5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb begin
        unique case (in_word.zone)
            ZONE_MID:  base_s = $signed({19'd0, cfg.base_80});
            ZONE_WIDE: base_s = $signed({19'd0, cfg.base_60});
            default:   base_s = $signed({19'd0, cfg.base_full});
        endcase
        pid_s = $signed({in_word.pid[PID_W-1], in_word.pid});
        if (pid_s > base_s) begin
            pid_lim = base_s;
        end else if (pid_s < -base_s) begin
            pid_lim = -base_s;
        end else begin
            pid_lim = pid_s;
        end

        sl             = '0;
        sr             = '0;
        left_fold      = '0;
        right_fold     = '0;
        left_mag_next  = '0;
        right_mag_next = '0;
        left_rev_next  = 1'b0;
        right_rev_next = 1'b0;

        unique case (in_word.zone)
            ZONE_NEAR: begin
                if (pid_lim[35]) begin
                    sr = base_s;
                    sl = base_s - pid_lim;
                end else begin
                    sr = base_s + pid_lim;
                    sl = base_s;
                end
                left_mag_next  = sl[17:0];
                right_mag_next = sr[17:0];
            end
            ZONE_MID: begin
                sr             = base_s + pid_lim;
                sl             = base_s - pid_lim;
                left_mag_next  = sl[17:0];
                right_mag_next = sr[17:0];
            end
            ZONE_WIDE: begin
                if (pid_lim[35]) begin
                    sr = '0;
                    sl = base_s - pid_lim;
                end else begin
                    sr = base_s + pid_lim;
                    sl = '0;
                end
                left_mag_next  = sl[17:0];
                right_mag_next = sr[17:0];
            end
            ZONE_FAR: begin
                // pid unlimited here, motors may turn backward
                if (pid_s[35]) begin
                    sr = pid_s - base_s;
                    sl = base_s - pid_s;
                end else begin
                    sr = base_s + pid_s;
                    sl = -base_s - pid_s;
                end
                left_fold      = far_fold(sl, base_s);
                right_fold     = far_fold(sr, base_s);
                left_rev_next  = left_fold[18];
                left_mag_next  = left_fold[17:0];
                right_rev_next = right_fold[18];
                right_mag_next = right_fold[17:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (rdy5) begin
                vld5_reg <= in_valid;
            end
            if (rdy6) begin
                vld6_reg <= vld5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            left_mag5_reg  <= left_mag_next;
            right_mag5_reg <= right_mag_next;
            left_rev5_reg  <= left_rev_next;
            right_rev5_reg <= right_rev_next;
        end
        if (rdy6) begin
            // saturate at full pwm, low active compare value is the complement
            left_pwm_reg  <= (|left_mag5_reg[17:16]) ? 16'd0 : ~left_mag5_reg[15:0];
            right_pwm_reg <= (|right_mag5_reg[17:16]) ? 16'd0 : ~right_mag5_reg[15:0];
            left_rev_reg  <= left_rev5_reg;
            right_rev_reg <= right_rev5_reg;
        end
    end

    assign m_tvalid = vld6_reg;
    assign m_tdata  = {6'd0, right_rev_reg, right_pwm_reg, left_rev_reg, left_pwm_reg};

endmodule

### design/pid_line_follow_steer_unit.sv
// top level of the pid line follow steering unit
//
// usage:
//   s_ channel carries one sensor word per control step: measured and target
//   line position. m_ channel returns one word per input word with the left
//   and right pwm compare values (low active) and the two reverse bits.
//   the cfg_ port writes gains, windup limit and max speed; the user does so
//   only while idle, unenforced; a written value is in effect for the next accepted word.
// pipeline: a result word passes six register stages (state update, split
//   multiply, divide by 100, term sum, zone mix, pwm register).
// throughput: one word per cycle unless stalled; the error integral and
//   previous error are updated on accept so consecutive words follow back to back.
// stall: when m_tready is low the stages fill up behind the output register;
//   s_tready drops only once every stage holds a word, no word is dropped.
// reset: aresetn low clears all configuration registers, the integral, the
//   previous error and all valid flags; no result is pending afterward.
`timescale 1ns / 1ps

module pid_line_follow_steer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // measured_position, target_position
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,   // left_pwm, left_reverse, right_pwm,
                                                        // right_reverse, zero fill
    input  logic                             cfg_wr_en,
    input  logic [pls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import pls_pkg::*;

    cfg_t      cfg;
    pid_word_t pid_word;
    logic      pid_valid, pid_ready;

    pls_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pls_pid u_pid (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .measured_position (s_tdata[15:0]),
        .target_position   (s_tdata[31:16]),
        .out_valid         (pid_valid),
        .out_ready         (pid_ready),
        .out_word          (pid_word)
    );

    pls_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (pid_valid),
        .in_ready (pid_ready),
        .in_word  (pid_word),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/sv/tb.sv
// testbench for the pid line follow steering unit: directed table, then random runs
`timescale 1ns / 1ps

module tb;

    import pls_pkg::*;

    localparam int POS_SPAN   = 6000;
    localparam int PCT_STEP   = POS_SPAN / 2 / 100;
    localparam int PWM_TOP    = 65535;
    localparam int SPEED_STEP = PWM_TOP / 100;
    localparam int PIPE_DEPTH = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic        right_rev;
        logic [15:0] right_pwm;
        logic        left_rev;
        logic [15:0] left_pwm;
    } steer_res_t;

    typedef struct packed {
        logic [15:0] prop;
        logic [15:0] integ;
        logic [15:0] deriv;
        logic [22:0] windup;
        logic [6:0]  speed;
    } steer_regs_t;

    typedef enum logic [1:0] {
        ROW_REGS,
        ROW_SPARE,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        steer_regs_t regs;
        logic [15:0] meas;
        logic [15:0] targ;
        logic        pinned;
        steer_res_t  res;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;   // measured_position, target_position
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [39:0]            m_tdata;        // left_pwm, left_reverse, right_pwm,
                                            // right_reverse, zero fill
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pid_line_follow_steer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // predictor copy of registers and loop state
    logic [15:0] kp, ki, kd;
    logic [22:0] wind_lim;
    logic [6:0]  top_pct;
    longint      integ_acc;
    longint      last_err;

    steer_res_t  pwm_due[$];
    stim_row_t   dir_rows[$];
    bit          idle_on = 1'b1;
    int          rdy_hold = 0;
    int          fault_cnt = 0;
    int          words_sent = 0;
    int          words_seen = 0;
    int          reg_writes = 0;
    int          clamp_hits = 0;
    int          zone_hits[4] = '{0, 0, 0, 0};
    steer_res_t  want;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic steer_res_t steer_predict(input logic [15:0] meas,
                                                 input logic [15:0] targ);
        longint err, lim, pid, base, full, sl, sr, pct, gp, gi, gd, span;
        logic rl, rr;
        steer_res_t r;
        gp = kp;
        gi = ki;
        gd = kd;
        lim = wind_lim;
        full = top_pct;
        full = full * SPEED_STEP;
        span = targ;
        err = span;
        span = meas;
        err = err - span;
        rl = 1'b0;
        rr = 1'b0;

        if (integ_acc + err > lim || integ_acc + err < -lim) clamp_hits++;
        integ_acc = clip(integ_acc + err, -lim, lim);
        pid = (err * gp) / 100;
        pid += (integ_acc * gi) / 100;
        pid += ((err - last_err) * gd) / 100;
        last_err = err;

        pct = (err < 0 ? -err : err) / PCT_STEP;
        if (pct > 255) pct = 255;

        if (pct <= 20) begin
            zone_hits[ZONE_NEAR]++;
            base = full;
            pid = clip(pid, -base, base);
            if (pid < 0) begin
                sr = base;
                sl = base - pid;
            end else begin
                sr = base + pid;
                sl = base;
            end
        end else if (pct <= 40) begin
            zone_hits[ZONE_MID]++;
            base = full * 8 / 10;
            pid = clip(pid, -base, base);
            sr = base + pid;
            sl = base - pid;
        end else if (pct <= 70) begin
            zone_hits[ZONE_WIDE]++;
            base = full * 6 / 10;
            pid = clip(pid, -base, base);
            if (pid < 0) begin
                sr = 0;
                sl = base - pid;
            end else begin
                sr = base + pid;
                sl = 0;
            end
        end else begin
            zone_hits[ZONE_FAR]++;
            base = full;
            if (pid < 0) begin
                sr = -base + pid;
                sl = base - pid;
            end else begin
                sr = base + pid;
                sl = -base - pid;
            end
            sl = clip(sl, -base, base);
            sr = clip(sr, -base, base);
            if (sl < 0) begin
                rl = 1'b1;
                sl = -sl;
            end
            if (sr < 0) begin
                rr = 1'b1;
                sr = -sr;
            end
        end

        sl = clip(sl, 0, PWM_TOP);
        sr = clip(sr, 0, PWM_TOP);
        r.left_pwm  = 16'(PWM_TOP - sl);
        r.left_rev  = rl;
        r.right_pwm = 16'(PWM_TOP - sr);
        r.right_rev = rr;
        return r;
    endfunction

    function automatic stim_row_t regs_row(input int p, input int i, input int d,
                                           input int w, input int s);
        stim_row_t r;
        r = '0;
        r.kind        = ROW_REGS;
        r.regs.prop   = 16'(p);
        r.regs.integ  = 16'(i);
        r.regs.deriv  = 16'(d);
        r.regs.windup = 23'(w);
        r.regs.speed  = 7'(s);
        return r;
    endfunction

    function automatic stim_row_t word_row(input int m, input int t);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.meas = 16'(m);
        r.targ = 16'(t);
        return r;
    endfunction

    function automatic stim_row_t word_chk(input int m, input int t, input int lp,
                                           input int lr, input int rp, input int rr);
        stim_row_t r;
        r = word_row(m, t);
        r.pinned        = 1'b1;
        r.res.left_pwm  = 16'(lp);
        r.res.left_rev  = 1'(lr);
        r.res.right_pwm = 16'(rp);
        r.res.right_rev = 1'(rr);
        return r;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic steer_regs_t pick_regs();
        steer_regs_t c;
        c.prop  = pick_gain();
        c.integ = pick_gain();
        c.deriv = pick_gain();
        case ($urandom_range(0, 3))
            0:       c.windup = 23'd0;
            1:       c.windup = 23'h7fffff;
            2:       c.windup = 23'($urandom_range(0, 20000));
            default: c.windup = 23'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       c.speed = 7'd0;
            1:       c.speed = 7'd100;
            2:       c.speed = 7'd127;
            default: c.speed = 7'($urandom_range(0, 127));
        endcase
        return c;
    endfunction

    task automatic log_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // class 0..4 walks the zones out to the saturated percent, 5 is noise
    task automatic pick_word(input int cls, input bit neg,
                             output logic [15:0] meas, output logic [15:0] targ);
        int mag, lo;
        if (cls >= 5) begin
            meas = 16'($urandom);
            targ = 16'($urandom);
        end else begin
            case (cls)
                0:       mag = $urandom_range(0, 21 * PCT_STEP - 1);
                1:       mag = $urandom_range(21 * PCT_STEP, 41 * PCT_STEP - 1);
                2:       mag = $urandom_range(41 * PCT_STEP, 71 * PCT_STEP - 1);
                3:       mag = $urandom_range(71 * PCT_STEP, 256 * PCT_STEP - 1);
                default: mag = $urandom_range(256 * PCT_STEP, PWM_TOP);
            endcase
            if ($urandom_range(0, 1) == 1 && mag <= POS_SPAN / 2)
                lo = neg ? POS_SPAN / 2 : POS_SPAN / 2 - mag;
            else
                lo = $urandom_range(0, PWM_TOP - mag);
            if (neg) begin
                targ = 16'(lo);
                meas = 16'(lo + mag);
            end else begin
                meas = 16'(lo);
                targ = 16'(lo + mag);
            end
        end
    endtask

    task automatic send_word(input logic [15:0] meas, input logic [15:0] targ,
                             input logic pinned, input steer_res_t pin_res);
        steer_res_t calc;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {targ, meas};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        calc = steer_predict(meas, targ);
        pwm_due.push_back(pinned ? pin_res : calc);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pwm_due.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [22:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        reg_writes++;
        case (idx)
            REG_PROP_GAIN:  kp = val[15:0];
            REG_INTEG_GAIN: ki = val[15:0];
            REG_DERIV_GAIN: kd = val[15:0];
            REG_WINDUP:     wind_lim = val;
            REG_MAX_SPEED:  top_pct = val[6:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input steer_regs_t c);
        wait_drained();
        put_reg(REG_PROP_GAIN, {7'd0, c.prop});
        put_reg(REG_INTEG_GAIN, {7'd0, c.integ});
        put_reg(REG_DERIV_GAIN, {7'd0, c.deriv});
        put_reg(REG_WINDUP, c.windup);
        put_reg(REG_MAX_SPEED, {16'd0, c.speed});
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (!idle_on) begin
            rdy_hold = 0;
            m_tready <= 1'b1;
        end else begin
            if (rdy_hold == 0 && $urandom_range(0, 5) == 0) rdy_hold = $urandom_range(1, 9);
            if (rdy_hold != 0) begin
                rdy_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pwm_due.size() == 0) begin
                log_fault($sformatf("result word %h with nothing expected", m_tdata));
            end else begin
                want = pwm_due.pop_front();
                if (m_tdata[15:0] != want.left_pwm || m_tdata[16] != want.left_rev ||
                    m_tdata[32:17] != want.right_pwm || m_tdata[33] != want.right_rev ||
                    m_tdata[39:34] != 6'd0)
                    log_fault($sformatf({"word %0d: expected lpwm %0d lrev %0b rpwm %0d ",
                        "rrev %0b, got lpwm %0d lrev %0b rpwm %0d rrev %0b fill %h"},
                        words_seen, want.left_pwm, want.left_rev, want.right_pwm,
                        want.right_rev, m_tdata[15:0], m_tdata[16], m_tdata[32:17],
                        m_tdata[33], m_tdata[39:34]));
            end
        end
    end

    initial begin : stim
        logic [15:0] meas, targ;
        int ph, n, k, run, cls;
        bit neg;
        steer_res_t left_over;
        int lost_cnt;

        kp = '0;
        ki = '0;
        kd = '0;
        wind_lim = '0;
        top_pct = '0;
        integ_acc = 0;
        last_err = 0;
        lost_cnt = 0;

        // all registers zero after reset: speed 0, so every pwm sits at full scale
        dir_rows.push_back(word_chk(0, 0, 65535, 0, 65535, 0));
        dir_rows.push_back(word_chk(65535, 0, 65535, 0, 65535, 0));
        dir_rows.push_back(word_chk(0, 65535, 65535, 0, 65535, 0));
        dir_rows.push_back(word_chk(16'haaaa, 16'h5555, 65535, 0, 65535, 0));
        dir_rows.push_back(regs_row(100, 0, 0, 0, 100));
        dir_rows.push_back(word_chk(3000, 3000, 35, 0, 35, 0));
        dir_rows.push_back(word_row(3000, 3300));
        dir_rows.push_back(word_row(3300, 3000));
        // zone edges at 20/21, 40/41 and 70/71 percent
        dir_rows.push_back(word_row(3000, 3629));
        dir_rows.push_back(word_row(3000, 3630));
        dir_rows.push_back(word_row(3000, 4229));
        dir_rows.push_back(word_row(4230, 3000));
        dir_rows.push_back(word_row(3000, 5129));
        dir_rows.push_back(word_row(5130, 3000));
        dir_rows.push_back(word_chk(0, 65535, 35, 1, 35, 0));
        // extremes, speed past 100 percent hits the final speed clamp
        dir_rows.push_back(regs_row(65535, 65535, 65535, 8388607, 127));
        dir_rows.push_back(word_row(0, 65535));
        dir_rows.push_back(word_row(0, 65535));
        dir_rows.push_back(word_row(65535, 0));
        dir_rows.push_back(word_row(32768, 32767));
        // windup lowered under a wound up integral
        dir_rows.push_back(regs_row(0, 100, 0, 1000, 50));
        dir_rows.push_back(word_row(3000, 3000));
        dir_rows.push_back(word_row(3000, 3010));
        // zero speed with proportional and derivative gain
        dir_rows.push_back(regs_row(50, 0, 300, 0, 0));
        dir_rows.push_back(word_row(3000, 3500));
        dir_rows.push_back(word_row(3500, 3000));
        dir_rows.push_back(stim_row_t'({ROW_SPARE, {$bits(stim_row_t) - 2{1'b0}}}));
        dir_rows.push_back(word_row(3000, 3200));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[j]) begin
            case (dir_rows[j].kind)
                ROW_REGS: load_regs(dir_rows[j].regs);
                ROW_SPARE: begin
                    wait_drained();
                    put_reg(REG_SPARE, 23'($urandom));
                    cfg_wr_en <= 1'b0;
                end
                default: send_word(dir_rows[j].meas, dir_rows[j].targ,
                                   dir_rows[j].pinned, dir_rows[j].res);
            endcase
        end

        // random phases; every phase starts from a fully drained pipeline
        for (ph = 0; ph < 14; ph++) begin
            idle_on = (ph % 4 != 3) && (ph < 12);
            load_regs(pick_regs());
            n = 0;
            while (n < 100) begin
                run = $urandom_range(1, 40);
                cls = $urandom_range(0, 5);
                neg = $urandom_range(0, 1);
                for (k = 0; k < run && n < 100; k++) begin
                    // mostly one sign per run so the integral winds up
                    pick_word(cls, ($urandom_range(0, 3) == 0) ? !neg : neg, meas, targ);
                    send_word(meas, targ, 1'b0, '0);
                    n++;
                end
            end
        end
        s_tvalid <= 1'b0;

        for (k = 0; k < 5000 && pwm_due.size() != 0; k++) @(posedge aclk);
        repeat (PIPE_DEPTH * 2) @(posedge aclk);
        while (pwm_due.size() != 0) begin
            left_over = pwm_due.pop_front();
            lost_cnt++;
            if (fault_cnt + lost_cnt <= 10)
                $display("ERROR: missing result: lpwm %0d rpwm %0d",
                         left_over.left_pwm, left_over.right_pwm);
        end

        $display("sent %0d words over %0d register writes; zones near %0d mid %0d wide %0d far %0d",
                 words_sent, reg_writes, zone_hits[ZONE_NEAR], zone_hits[ZONE_MID],
                 zone_hits[ZONE_WIDE], zone_hits[ZONE_FAR]);
        $display("integral clamp hit on %0d words, %0d results compared, %0d faults",
                 clamp_hits, words_seen, fault_cnt + lost_cnt);
        if (fault_cnt + lost_cnt == 0) begin
            $display("pid_line_follow_steer_unit test passed");
        end else begin
            $display("pid_line_follow_steer_unit test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", pwm_due.size());
        $display("pid_line_follow_steer_unit test failed");
        $finish;
    end

endmodule
